// ----- rtl/alht_pkg.sv -----
package alht_pkg;

    localparam int TABLE_BITS  = 12;
    localparam int TABLE_SIZE  = 1 << TABLE_BITS;
    localparam int PROBE_LIMIT = 96;
    localparam int PROBE_W     = $clog2(PROBE_LIMIT + 1);
    localparam int CLR_W       = TABLE_BITS + 1;

    localparam logic [63:0] MIX_CONST   = 64'hff51afd7ed558ccd;
    localparam logic [30:0] NEVER_FRAME = 31'h7FFFFFFF;

    // slot word, lowest bit first: key, serial, birth, death, live, arena, size
    localparam int SLOT_W = 64 + 64 + 31 + 31 + 1 + 1 + 32;

    typedef logic [TABLE_BITS-1:0] addr_t;

    typedef struct packed {
        logic [31:0] size;
        logic        arena;
        logic        live;
        logic [30:0] death;
        logic [30:0] birth;
        logic [63:0] serial;
        logic [63:0] key;
    } slot_t;

    typedef enum logic [1:0] {
        OP_ALLOC  = 2'd0,
        OP_RETIRE = 2'd1,
        OP_LOOKUP = 2'd2,
        OP_NONE   = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        ST_NEW      = 3'd0,
        ST_REUSED   = 3'd1,
        ST_FULL     = 3'd2,
        ST_RETIRED  = 3'd3,
        ST_MISS     = 3'd4,
        ST_FOUND    = 3'd5,
        ST_NOTFOUND = 3'd6,
        ST_REJECTED = 3'd7
    } status_t;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_MIX,
        S_HASH,
        S_READ,
        S_CHECK,
        S_OUT
    } state_t;

endpackage

// ----- rtl/address_lifetime_hash_table.sv -----
// Flow: an input beat passes S_MIX and S_HASH, then S_READ and S_CHECK for each probed
// slot, then S_OUT; a rejected beat is answered in the cycle after it is taken.
// Throughput: one operation at a time; a hit in the home slot passes the two hash stages
// and the read-check loop on the single slot memory read port.
// Reset: synchronous active-low aresetn; afterwards a clearing pass writes all
// 2^TABLE_BITS slots, one per cycle, with s_axis_tready low.
// Counters reset to zero.
module address_lifetime_hash_table (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // operation[1:0], address[65:2], block_size[97:66], frame_now[128:98],
    // arena_flag[129], zero pad to 136
    input  logic [135:0] s_axis_tdata,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // status[2:0], serial[66:3], birth_frame[97:67], death_frame[128:98],
    // is_live[129], arena_mark[130], stored_size[162:131], live_count[194:163],
    // full_count[226:195], zero pad to 232
    output logic [231:0] m_axis_tdata
);

    alht_pkg::state_t state_reg, state_next;

    logic [alht_pkg::CLR_W-1:0]   clr_reg;
    logic [alht_pkg::PROBE_W-1:0] probe_reg;
    alht_pkg::addr_t              slot_reg;
    logic [1:0]                   op_reg;
    logic [63:0]                  addr_reg;
    logic [31:0]                  size_reg;
    logic [30:0]                  frame_reg;
    logic                         arena_reg;
    logic [63:0]                  serial_reg;
    logic [31:0]                  live_reg;
    logic [31:0]                  full_reg;
    logic [231:0]                 out_reg;

    alht_pkg::addr_t home;
    alht_pkg::slot_t rd;
    logic [alht_pkg::SLOT_W-1:0] rdata;
    logic                        we;
    alht_pkg::addr_t             waddr;
    alht_pkg::slot_t             wd;
    logic                        in_beat;
    logic                        bad;

    assign in_beat = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = (state_reg == alht_pkg::S_IDLE);
    assign m_axis_tvalid = (state_reg == alht_pkg::S_OUT);
    assign m_axis_tdata  = out_reg;
    assign rd  = alht_pkg::slot_t'(rdata);
    assign bad = (s_axis_tdata[65:2] == 64'd0) || (s_axis_tdata[1:0] == alht_pkg::OP_NONE);

    alht_hash u_hash (
        .aclk    (aclk),
        .start   (in_beat),
        .address (s_axis_tdata[65:2]),
        .home    (home)
    );

    alht_ram #(.WIDTH(alht_pkg::SLOT_W), .DEPTH(alht_pkg::TABLE_SIZE)) u_slots (
        .aclk  (aclk),
        .we    (we),
        .waddr (waddr),
        .wdata (wd),
        .raddr (slot_reg),
        .rdata (rdata)
    );

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            alht_pkg::S_CLEAR: begin
                if (clr_reg == alht_pkg::CLR_W'(alht_pkg::TABLE_SIZE - 1))
                    state_next = alht_pkg::S_IDLE;
            end
            alht_pkg::S_IDLE: begin
                if (in_beat) state_next = bad ? alht_pkg::S_OUT : alht_pkg::S_MIX;
            end
            alht_pkg::S_MIX: state_next = alht_pkg::S_HASH;
            alht_pkg::S_HASH: state_next = alht_pkg::S_READ;
            alht_pkg::S_READ: state_next = alht_pkg::S_CHECK;
            alht_pkg::S_CHECK: begin
                if (rd.key == addr_reg || rd.key == 64'd0 ||
                    probe_reg == alht_pkg::PROBE_W'(alht_pkg::PROBE_LIMIT - 1))
                    state_next = alht_pkg::S_OUT;
                else
                    state_next = alht_pkg::S_READ;
            end
            alht_pkg::S_OUT: begin
                if (m_axis_tready) state_next = alht_pkg::S_IDLE;
            end
            default: state_next = alht_pkg::S_IDLE;
        endcase
    end

    // slot write: clearing pass, or the outcome of a probe check
    always_comb begin
        logic hit;
        logic empty;
        hit   = (rd.key == addr_reg);
        empty = (rd.key == 64'd0);
        we    = 1'b0;
        waddr = slot_reg;
        wd    = rd;
        case (state_reg)
            alht_pkg::S_CLEAR: begin
                we    = 1'b1;
                waddr = alht_pkg::addr_t'(clr_reg);
                wd    = '0;
            end
            alht_pkg::S_CHECK: begin
                if (op_reg == alht_pkg::OP_ALLOC && (hit || empty)) begin
                    we        = 1'b1;
                    wd.key    = addr_reg;
                    wd.serial = serial_reg + 64'd1;
                    wd.birth  = frame_reg;
                    wd.death  = alht_pkg::NEVER_FRAME;
                    wd.live   = 1'b1;
                    wd.arena  = arena_reg;
                    wd.size   = size_reg;
                end else if (op_reg == alht_pkg::OP_RETIRE && hit) begin
                    we       = 1'b1;
                    wd.death = frame_reg;
                    wd.live  = 1'b0;
                end
            end
            default: ;
        endcase
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= alht_pkg::S_CLEAR;
            clr_reg    <= '0;
            serial_reg <= '0;
            live_reg   <= '0;
            full_reg   <= '0;
        end else begin
            state_reg <= state_next;
            if (state_reg == alht_pkg::S_CLEAR) clr_reg <= clr_reg + 1'b1;
            if (state_reg == alht_pkg::S_CHECK) begin
                if (op_reg == alht_pkg::OP_ALLOC) begin
                    if (rd.key == addr_reg || rd.key == 64'd0) begin
                        serial_reg <= serial_reg + 64'd1;
                        if (!rd.live) live_reg <= live_reg + 32'd1;
                    end else if (state_next == alht_pkg::S_OUT) begin
                        full_reg <= full_reg + 32'd1;
                    end
                end else if (op_reg == alht_pkg::OP_RETIRE && rd.key == addr_reg &&
                             rd.live && live_reg != 32'd0) begin
                    live_reg <= live_reg - 32'd1;
                end
            end
        end
    end

    // capture the beat, walk the probe sequence, build the result
    always_ff @(posedge aclk) begin
        logic hit;
        logic empty;
        alht_pkg::status_t st;
        hit   = (rd.key == addr_reg);
        empty = (rd.key == 64'd0);
        st    = alht_pkg::ST_REJECTED;
        if (in_beat) begin
            op_reg    <= s_axis_tdata[1:0];
            addr_reg  <= s_axis_tdata[65:2];
            size_reg  <= s_axis_tdata[97:66];
            frame_reg <= s_axis_tdata[128:98];
            arena_reg <= s_axis_tdata[129];
            probe_reg <= '0;
            out_reg   <= {5'd0, full_reg, live_reg, 160'd0, alht_pkg::ST_REJECTED};
        end
        if (state_reg == alht_pkg::S_HASH) slot_reg <= home;
        if (state_reg == alht_pkg::S_CHECK) begin
            slot_reg  <= slot_reg + 1'b1;
            probe_reg <= probe_reg + 1'b1;
            if (state_next == alht_pkg::S_OUT) begin
                case (op_reg)
                    alht_pkg::OP_ALLOC:
                        st = hit ? alht_pkg::ST_REUSED :
                             (empty ? alht_pkg::ST_NEW : alht_pkg::ST_FULL);
                    alht_pkg::OP_RETIRE: st = hit ? alht_pkg::ST_RETIRED : alht_pkg::ST_MISS;
                    alht_pkg::OP_LOOKUP: st = hit ? alht_pkg::ST_FOUND : alht_pkg::ST_NOTFOUND;
                    default: st = alht_pkg::ST_REJECTED;
                endcase
                out_reg[2:0] <= st;
                if (st == alht_pkg::ST_NEW || st == alht_pkg::ST_REUSED ||
                    st == alht_pkg::ST_RETIRED || st == alht_pkg::ST_FOUND) begin
                    out_reg[162:3] <= {wd.size, wd.arena, wd.live, wd.death, wd.birth,
                                       wd.serial};
                end
                // counters after this operation
                if (op_reg == alht_pkg::OP_ALLOC) begin
                    if (hit || empty)
                        out_reg[194:163] <= rd.live ? live_reg : live_reg + 32'd1;
                    else
                        out_reg[226:195] <= full_reg + 32'd1;
                end else if (op_reg == alht_pkg::OP_RETIRE && hit && rd.live &&
                             live_reg != 32'd0) begin
                    out_reg[194:163] <= live_reg - 32'd1;
                end
            end
        end
    end

`ifndef NO_ASSERTIONS
    // no new beat is taken while a result waits
    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid |-> !s_axis_tready)
        else $error("input accepted while result pending");

    // a stalled result keeps its payload
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_axis_tvalid && !m_axis_tready) |=> $stable(m_axis_tdata))
        else $error("result changed while stalled");

    // the live count never moves outside a probe check
    a_live: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != alht_pkg::S_CHECK) |=> $stable(live_reg))
        else $error("live count moved outside check");
`endif

endmodule

// ----- rtl/alht_ram.sv -----
module alht_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port and registered read port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ----- rtl/alht_hash.sv -----
module alht_hash (
    input  logic                       aclk,
    input  logic                       start,
    input  logic [63:0]                address,
    output alht_pkg::addr_t            home
);

    logic [63:0] mix_reg;
    logic [63:0] prod_reg;
    logic [63:0] x0;
    logic [63:0] p;

    // first mix step, registered before the multiply
    assign x0 = (address >> 4) ^ (address >> 37);

    always_ff @(posedge aclk) begin
        if (start) begin
            mix_reg <= x0;
        end
        prod_reg <= p;
    end

    // 64-bit product split into 32x32 partial products, low 64 bits kept
    always_comb begin
        logic [63:0] ll;
        logic [31:0] lh;
        logic [31:0] hl;
        ll = 64'(mix_reg[31:0]) * 64'(alht_pkg::MIX_CONST[31:0]);
        lh = 32'(mix_reg[31:0] * alht_pkg::MIX_CONST[63:32]);
        hl = 32'(mix_reg[63:32] * alht_pkg::MIX_CONST[31:0]);
        p  = ll + {lh + hl, 32'd0};
    end

    assign home = alht_pkg::addr_t'(prod_reg ^ (prod_reg >> 33));

endmodule

// ----- tb/tb_address_lifetime_hash_table.sv -----
module tb_address_lifetime_hash_table;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [1:0]  operation;
        logic [63:0] address;
        logic [31:0] block_size;
        logic [30:0] frame_now;
        logic        arena_flag;
    } op_beat_t;

    typedef struct {
        alht_pkg::status_t status;
        logic [63:0] serial;
        logic [30:0] birth_frame;
        logic [30:0] death_frame;
        logic        is_live;
        logic        arena_mark;
        logic [31:0] stored_size;
        logic [31:0] live_count;
        logic [31:0] full_count;
    } answer_t;

    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [135:0] s_axis_tdata = '0;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic [231:0] m_axis_tdata;

    address_lifetime_hash_table dut (.*);

    always #1 aclk = ~aclk;

    // shadow table
    logic [63:0] tbl_key    [alht_pkg::TABLE_SIZE];
    logic [63:0] tbl_serial [alht_pkg::TABLE_SIZE];
    logic [30:0] tbl_birth  [alht_pkg::TABLE_SIZE];
    logic [30:0] tbl_death  [alht_pkg::TABLE_SIZE];
    logic        tbl_live   [alht_pkg::TABLE_SIZE];
    logic        tbl_arena  [alht_pkg::TABLE_SIZE];
    logic [31:0] tbl_size   [alht_pkg::TABLE_SIZE];
    logic [63:0] serial_ctr;
    logic [31:0] live_ctr;
    logic [31:0] full_ctr;

    op_beat_t    pending_ops[$];
    answer_t     expected_answers[$];
    logic [63:0] known_addrs[$];
    int          errors = 0;
    int          beats_out = 0;
    int          status_seen[8];
    bit          calm = 1'b0;
    bit          hold_send = 1'b0;
    bit          taken = 1'b0;

    function automatic logic [alht_pkg::TABLE_BITS-1:0] home_of(logic [63:0] a);
        logic [63:0] x;
        x = a >> 4;
        x ^= x >> 33;
        x = x * 64'hff51afd7ed558ccd;
        x ^= x >> 33;
        return x[alht_pkg::TABLE_BITS-1:0];
    endfunction

    // probe: 1 hit, 0 empty, -1 exhausted
    function automatic int find_slot(logic [63:0] a, output int where);
        int h;
        int s;
        h = int'(home_of(a));
        where = 0;
        for (int i = 0; i < alht_pkg::PROBE_LIMIT; i++) begin
            s = (h + i) % alht_pkg::TABLE_SIZE;
            if (tbl_key[s] == a) begin
                where = s;
                return 1;
            end
            if (tbl_key[s] == 64'd0) begin
                where = s;
                return 0;
            end
        end
        return -1;
    endfunction

    function automatic answer_t predict_answer(op_beat_t b);
        answer_t r;
        int s;
        int hit;
        bit fill;
        r.status = alht_pkg::ST_REJECTED;
        r.serial = '0;
        r.birth_frame = '0;
        r.death_frame = '0;
        r.is_live = 1'b0;
        r.arena_mark = 1'b0;
        r.stored_size = '0;
        fill = 1'b0;
        if (b.address != 64'd0 && b.operation != alht_pkg::OP_NONE) begin
            hit = find_slot(b.address, s);
            case (b.operation)
                alht_pkg::OP_ALLOC: begin
                    if (hit < 0) begin
                        full_ctr++;
                        r.status = alht_pkg::ST_FULL;
                    end else begin
                        if (!tbl_live[s]) live_ctr++;
                        tbl_key[s] = b.address;
                        serial_ctr++;
                        tbl_serial[s] = serial_ctr;
                        tbl_birth[s] = b.frame_now;
                        tbl_death[s] = alht_pkg::NEVER_FRAME;
                        tbl_arena[s] = b.arena_flag;
                        tbl_size[s] = b.block_size;
                        tbl_live[s] = 1'b1;
                        r.status = (hit == 1) ? alht_pkg::ST_REUSED : alht_pkg::ST_NEW;
                        fill = 1'b1;
                    end
                end
                alht_pkg::OP_RETIRE: begin
                    if (hit == 1) begin
                        tbl_death[s] = b.frame_now;
                        if (tbl_live[s] && live_ctr != 0) live_ctr--;
                        tbl_live[s] = 1'b0;
                        r.status = alht_pkg::ST_RETIRED;
                        fill = 1'b1;
                    end else begin
                        r.status = alht_pkg::ST_MISS;
                    end
                end
                default: begin
                    r.status = (hit == 1) ? alht_pkg::ST_FOUND : alht_pkg::ST_NOTFOUND;
                    fill = (hit == 1);
                end
            endcase
            if (fill) begin
                r.serial = tbl_serial[s];
                r.birth_frame = tbl_birth[s];
                r.death_frame = tbl_death[s];
                r.is_live = tbl_live[s];
                r.arena_mark = tbl_arena[s];
                r.stored_size = tbl_size[s];
            end
        end
        r.live_count = live_ctr;
        r.full_count = full_ctr;
        return r;
    endfunction

    function automatic op_beat_t make_op(logic [1:0] op, logic [63:0] a, logic [31:0] sz,
                                         logic [30:0] fr, logic ar);
        op_beat_t b;
        b.operation = op;
        b.address = a;
        b.block_size = sz;
        b.frame_now = fr;
        b.arena_flag = ar;
        return b;
    endfunction

    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    // addresses that share one home slot, to build long probe chains
    function automatic logic [63:0] colliding_addr(logic [alht_pkg::TABLE_BITS-1:0] target);
        logic [63:0] a;
        do a = rand64() | 64'd16; while (home_of(a) != target);
        return a;
    endfunction

    task automatic push_op(op_beat_t b);
        pending_ops.push_back(b);
        if (b.operation == alht_pkg::OP_ALLOC && b.address != 0) known_addrs.push_back(b.address);
    endtask

    // driver: change inputs on the falling edge, advance only after an accepted beat
    always @(negedge aclk) begin
        if (aresetn) begin
            if (taken) void'(pending_ops.pop_front());
            if (!s_axis_tvalid || taken) begin
                if (pending_ops.size() > 0 && !hold_send &&
                    (calm || $urandom_range(99) >= 30)) begin
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata <= {6'd0, pending_ops[0].arena_flag, pending_ops[0].frame_now,
                                     pending_ops[0].block_size, pending_ops[0].address,
                                     pending_ops[0].operation};
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
            m_axis_tready <= calm || ($urandom_range(99) >= 30);
        end
    end

    // input accept: predict at the rising edge
    always @(posedge aclk) begin
        taken <= aresetn && s_axis_tvalid && s_axis_tready;
        if (aresetn && s_axis_tvalid && s_axis_tready)
            expected_answers.push_back(predict_answer(make_op(s_axis_tdata[1:0],
                s_axis_tdata[65:2], s_axis_tdata[97:66], s_axis_tdata[128:98],
                s_axis_tdata[129])));
    end

    // monitor: compare every result beat with the oldest expectation
    always @(posedge aclk) begin
        answer_t e;
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            beats_out++;
            if (expected_answers.size() == 0) begin
                $error("result beat with nothing expected");
                errors++;
            end else begin
                e = expected_answers.pop_front();
                status_seen[e.status]++;
                if (m_axis_tdata[2:0] !== e.status) begin
                    $error("status exp %0d got %0d", e.status, m_axis_tdata[2:0]); errors++;
                end
                if (m_axis_tdata[66:3] !== e.serial) begin
                    $error("serial exp %0h got %0h", e.serial, m_axis_tdata[66:3]); errors++;
                end
                if (m_axis_tdata[97:67] !== e.birth_frame) begin
                    $error("birth_frame exp %0h got %0h", e.birth_frame, m_axis_tdata[97:67]);
                    errors++;
                end
                if (m_axis_tdata[128:98] !== e.death_frame) begin
                    $error("death_frame exp %0h got %0h", e.death_frame, m_axis_tdata[128:98]);
                    errors++;
                end
                if (m_axis_tdata[129] !== e.is_live) begin
                    $error("is_live exp %0b got %0b", e.is_live, m_axis_tdata[129]); errors++;
                end
                if (m_axis_tdata[130] !== e.arena_mark) begin
                    $error("arena_mark exp %0b got %0b", e.arena_mark, m_axis_tdata[130]);
                    errors++;
                end
                if (m_axis_tdata[162:131] !== e.stored_size) begin
                    $error("stored_size exp %0h got %0h", e.stored_size, m_axis_tdata[162:131]);
                    errors++;
                end
                if (m_axis_tdata[194:163] !== e.live_count) begin
                    $error("live_count exp %0d got %0d", e.live_count, m_axis_tdata[194:163]);
                    errors++;
                end
                if (m_axis_tdata[226:195] !== e.full_count) begin
                    $error("full_count exp %0d got %0d", e.full_count, m_axis_tdata[226:195]);
                    errors++;
                end
            end
        end
    end

    // watchdog
    initial begin
        #2000000;
        $display("tb_address_lifetime_hash_table: FAIL");
        $finish;
    end

    initial begin
        logic [63:0] a;
        logic [63:0] chain[$];
        logic [alht_pkg::TABLE_BITS-1:0] target;
        int pick;
        for (int i = 0; i < alht_pkg::TABLE_SIZE; i++) begin
            tbl_key[i] = 0; tbl_serial[i] = 0; tbl_birth[i] = 0; tbl_death[i] = 0;
            tbl_live[i] = 0; tbl_arena[i] = 0; tbl_size[i] = 0;
        end
        serial_ctr = 0; live_ctr = 0; full_ctr = 0;
        foreach (status_seen[i]) status_seen[i] = 0;

        // directed: extremes, every operation, zero address, unknown operation
        push_op(make_op(alht_pkg::OP_LOOKUP, 64'hFFFF_FFFF_FFFF_FFFF, '0, '0, 1'b0));
        push_op(make_op(alht_pkg::OP_ALLOC, 64'hFFFF_FFFF_FFFF_FFFF, '1, '1, 1'b1));
        push_op(make_op(alht_pkg::OP_ALLOC, 64'd1, '0, '0, 1'b0));
        push_op(make_op(alht_pkg::OP_ALLOC, 64'hFFFF_FFFF_FFFF_FFFF, 32'h1234, 31'd5, 1'b0));
        push_op(make_op(alht_pkg::OP_LOOKUP, 64'd1, '1, '1, 1'b1));
        push_op(make_op(alht_pkg::OP_RETIRE, 64'd1, '1, '1, 1'b1));
        push_op(make_op(alht_pkg::OP_RETIRE, 64'd1, '0, 31'd7, 1'b0));
        push_op(make_op(alht_pkg::OP_LOOKUP, 64'd1, '0, '0, 1'b0));
        push_op(make_op(alht_pkg::OP_ALLOC, 64'd1, 32'h55, 31'd9, 1'b1));
        push_op(make_op(alht_pkg::OP_RETIRE, 64'hDEAD_0000, '0, '0, 1'b0));
        push_op(make_op(alht_pkg::OP_ALLOC, 64'd0, '1, '1, 1'b1));
        push_op(make_op(alht_pkg::OP_RETIRE, 64'd0, '1, '1, 1'b1));
        push_op(make_op(alht_pkg::OP_LOOKUP, 64'd0, '0, '0, 1'b0));
        push_op(make_op(alht_pkg::OP_NONE, 64'd1, '0, '0, 1'b0));
        push_op(make_op(alht_pkg::OP_NONE, 64'hFFFF_FFFF_FFFF_FFFF, '1, '1, 1'b1));
        push_op(make_op(alht_pkg::OP_LOOKUP, 64'hFFFF_FFFF_FFFF_FFFF, '0, '0, 1'b0));

        // fill one probe chain past the limit so alloc reports full
        target = alht_pkg::addr_t'($urandom());
        for (int i = 0; i < alht_pkg::PROBE_LIMIT + 2; i++) begin
            a = colliding_addr(target);
            chain.push_back(a);
            push_op(make_op(alht_pkg::OP_ALLOC, a, $urandom(), 31'($urandom()),
                            1'($urandom_range(1))));
        end
        push_op(make_op(alht_pkg::OP_LOOKUP, chain[alht_pkg::PROBE_LIMIT - 1], '0, '0, 1'b0));
        push_op(make_op(alht_pkg::OP_RETIRE, chain[alht_pkg::PROBE_LIMIT + 1], '0, '0, 1'b0));

        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        // random: mostly operations on known addresses, some fresh or odd
        for (int n = 0; n < 820; n++) begin
            pick = $urandom_range(99);
            if (pick < 8) a = colliding_addr(target);
            else if (pick < 60 && known_addrs.size() > 0)
                a = known_addrs[$urandom_range(known_addrs.size() - 1)];
            else if (pick < 63) a = 64'd0;
            else a = rand64();
            pick = $urandom_range(99);
            push_op(make_op(pick < 40 ? alht_pkg::OP_ALLOC : pick < 65 ? alht_pkg::OP_RETIRE :
                            pick < 97 ? alht_pkg::OP_LOOKUP : alht_pkg::OP_NONE,
                            a, $urandom(), 31'($urandom()), 1'($urandom_range(1))));
            // pause the sender once until the block has drained
            if (n == 300) begin
                wait (pending_ops.size() == 0);
                hold_send = 1'b1;
                wait (expected_answers.size() == 0);
                @(negedge aclk);
                hold_send = 1'b0;
            end
            // run a stretch of beats with no idling on either side
            if (n == 450) begin
                wait (pending_ops.size() == 0);
                calm = 1'b1;
            end
            if (n == 600) begin
                wait (pending_ops.size() == 0);
                calm = 1'b0;
            end
        end

        wait (pending_ops.size() == 0 && !s_axis_tvalid);
        wait (expected_answers.size() == 0);
        repeat (500) @(posedge aclk);
        $display("Covered %0d result beats: new %0d reused %0d full %0d retired %0d",
                 beats_out, status_seen[alht_pkg::ST_NEW], status_seen[alht_pkg::ST_REUSED],
                 status_seen[alht_pkg::ST_FULL], status_seen[alht_pkg::ST_RETIRED]);
        $display("  retire miss %0d found %0d not found %0d rejected %0d",
                 status_seen[alht_pkg::ST_MISS], status_seen[alht_pkg::ST_FOUND],
                 status_seen[alht_pkg::ST_NOTFOUND], status_seen[alht_pkg::ST_REJECTED]);
        if (errors == 0 && expected_answers.size() == 0)
            $display("tb_address_lifetime_hash_table: PASS");
        else
            $display("tb_address_lifetime_hash_table: FAIL");
        $finish;
    end
endmodule
